@@ design/blit_rect_tile_splitter_top_defines.svh @@
// Assertion macros for the blit tile splitter blocks.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef BLIT_RECT_TILE_SPLITTER_TOP_DEFINES_SVH
`define BLIT_RECT_TILE_SPLITTER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is applied.
`define BRTS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is applied.
`define BRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/brts_pkg.sv @@
// Shared types and constants of the blit tile splitter.
// No dependencies; every other design file but the macro header refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package brts_pkg;

	localparam int MAX_TILES_PER_SIDE_DEF  = 64;
	localparam int MAX_PIECES_PER_AXIS_DEF = 8;

	localparam int TS_MAX      = 10;   // largest usable tile_shift
	localparam int RS_MAX      = 6;    // largest usable row_shift
	localparam int SIDE_HW_MAX = 64;   // 1 << RS_MAX
	localparam int SIDE_W      = 7;    // holds SIDE_HW_MAX
	localparam int PCNT_W      = 4;    // piece count per axis, up to 8
	localparam int PIDX_W      = 3;    // piece slot index per axis, 0..7
	localparam int JOBQ_DEPTH  = 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_SHIFT = 1'b0,
		REG_ROW_SHIFT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0] ts;
		logic [2:0] rs;
	} cfg_t;

	typedef struct packed {
		logic [15:0] src_x;
		logic [15:0] src_y;
		logic [15:0] dst_x;
		logic [15:0] dst_y;
		logic [15:0] rect_w;
		logic [15:0] rect_h;
	} req_t;

	typedef struct packed {
		logic [15:0] piece_src_x;
		logic [15:0] piece_src_y;
		logic [10:0] piece_w;
		logic [10:0] piece_h;
		logic [11:0] tile_index;
		logic [9:0]  local_x;
		logic [9:0]  local_y;
		logic        newly_used;
		logic        out_of_range;
		logic        empty_res;
		logic        truncated;
		logic        final_piece;
	} piece_t;

	// One classified request, handed from front to back.
	typedef struct packed {
		logic [15:0]       sdx;    // src_x - dst_x, mod 2^16
		logic [15:0]       sdy;
		logic [15:0]       dx;
		logic [15:0]       dy;
		logic [15:0]       bx;     // dst_x rounded down to the tile grid
		logic [15:0]       by;
		logic [16:0]       endx;   // dst_x + rect_w, no wrap
		logic [16:0]       endy;
		logic [PCNT_W-1:0] nx;
		logic [PCNT_W-1:0] ny;
		logic              trunc;
		logic              empty;
	} job_t;

endpackage

`default_nettype wire

@@ design/brts_front.sv @@
// Front end: accepts a blit request and classifies it into a job.
// Depends on brts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brts_front #(
	parameter int MAX_PIECES_PER_AXIS = brts_pkg::MAX_PIECES_PER_AXIS_DEF
) (
	input  wire logic          [3:0] tile_shift,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire brts_pkg::req_t      req,
	input  wire logic                q_full,
	input  wire logic                clear_busy,
	output logic                     push,
	output brts_pkg::job_t           job
);

	localparam logic [brts_pkg::PCNT_W-1:0] MAXP = brts_pkg::PCNT_W'(MAX_PIECES_PER_AXIS);

	logic [10:0] tsize;
	logic [9:0]  mask;
	logic [9:0]  offx, offy;
	logic [16:0] sumx, sumy;
	logic [16:0] cx, cy;

	assign tsize = 11'(1) << tile_shift;
	assign mask  = 10'(tsize - 11'd1);
	assign offx  = req.dst_x[9:0] & mask;
	assign offy  = req.dst_y[9:0] & mask;

	// Slot count: tiles spanned from the aligned base to the far edge.
	assign sumx = 17'(offx) + 17'(req.rect_w) + 17'(mask);
	assign sumy = 17'(offy) + 17'(req.rect_h) + 17'(mask);
	assign cx   = (req.rect_w == 16'd0) ? 17'd0 : (sumx >> tile_shift);
	assign cy   = (req.rect_h == 16'd0) ? 17'd0 : (sumy >> tile_shift);

	always_comb begin
		job.sdx   = req.src_x - req.dst_x;
		job.sdy   = req.src_y - req.dst_y;
		job.dx    = req.dst_x;
		job.dy    = req.dst_y;
		job.bx    = req.dst_x & ~{6'd0, mask};
		job.by    = req.dst_y & ~{6'd0, mask};
		job.endx  = 17'(req.dst_x) + 17'(req.rect_w);
		job.endy  = 17'(req.dst_y) + 17'(req.rect_h);
		job.nx    = (cx > 17'(MAXP)) ? MAXP : cx[brts_pkg::PCNT_W-1:0];
		job.ny    = (cy > 17'(MAXP)) ? MAXP : cy[brts_pkg::PCNT_W-1:0];
		job.trunc = (cx > 17'(MAXP)) || (cy > 17'(MAXP));
		job.empty = (cx == 17'd0) || (cy == 17'd0);
	end

	// Hold off requests while the tile store clears or the queue is full.
	assign req_ready = !q_full && !clear_busy;
	assign push      = req_valid && req_ready;

endmodule

`default_nettype wire

@@ design/brts_jobq.sv @@
// Short job queue between the front and back ends.
// Depends on brts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "blit_rect_tile_splitter_top_defines.svh"

module brts_jobq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire brts_pkg::job_t wdata,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output brts_pkg::job_t      rdata
);

	localparam int DEPTH = brts_pkg::JOBQ_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	brts_pkg::job_t  entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	`BRTS_ASSERT_IMPL(a_jobq_no_overflow, push, !full || pop, "job queue written while full")
	`BRTS_ASSERT_NEXT(a_jobq_drain, pop && !push && (count_q == CW'(1)), !valid, "queue not empty after last pop")

endmodule

`default_nettype wire

@@ design/brts_back.sv @@
// Back end: walks the tile slots of each job, looks up the tile-in-use store
// and emits one piece per cycle unless the piece output stalls. Depends on brts_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "blit_rect_tile_splitter_top_defines.svh"

module brts_back #(
	parameter int MAX_TILES_PER_SIDE  = brts_pkg::MAX_TILES_PER_SIDE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire brts_pkg::cfg_t cfg,
	input  wire logic           job_valid,
	input  wire brts_pkg::job_t job,
	output logic                job_pop,
	output logic                clear_busy,
	output logic                piece_valid,
	input  wire logic           piece_ready,
	output brts_pkg::piece_t    piece
);

	localparam int SIDE_CAP = (MAX_TILES_PER_SIDE < brts_pkg::SIDE_HW_MAX) ?
		MAX_TILES_PER_SIDE : brts_pkg::SIDE_HW_MAX;
	localparam int DEPTH    = SIDE_CAP * SIDE_CAP;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIDX_W   = brts_pkg::PIDX_W;
	localparam int SIDE_W   = brts_pkg::SIDE_W;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	typedef struct packed {
		brts_pkg::piece_t pc;
		logic             mark;
		logic [AW-1:0]    idx;
	} stage_t;

	state_t        state_q;
	logic [AW-1:0] clr_addr_q;

	logic          tile_in_use_q [DEPTH];
	logic          rd_q;

	logic [PIDX_W-1:0] i_q, j_q;
	logic [16:0]       posx_q, posy_q;

	logic              s1_v, s2_v, piece_valid_q;
	stage_t            s1, s2;
	logic              s2_hit;
	brts_pkg::piece_t  piece_q;
	brts_pkg::piece_t  piece_d;

	logic              en, gen_v, last_row, last_col, last;
	logic [16:0]       tsize;
	logic [9:0]        mask;
	logic [7:0]        side_pow;
	logic [SIDE_W-1:0] side;
	logic [16:0]       posx_cur, posy_cur, hix, hiy, lox, loy, endx_c, endy_c;
	logic [16:0]       pw, ph;
	logic [15:0]       col, row;
	logic              oor;
	logic [12:0]       idx_full;
	stage_t            gen;

	assign tsize    = 17'(1) << cfg.ts;
	assign mask     = 10'(tsize - 17'd1);
	assign side_pow = 8'(1) << cfg.rs;
	assign side     = (side_pow > 8'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : SIDE_W'(side_pow);

	assign en    = !piece_valid_q || piece_ready;
	assign gen_v = job_valid && (state_q == ST_RUN);

	// Slot geometry on each axis: slot 0 starts at the destination corner.
	assign posx_cur = (i_q == '0) ? {1'b0, job.bx} : posx_q;
	assign posy_cur = (j_q == '0) ? {1'b0, job.by} : posy_q;
	assign hix      = posx_cur + tsize;
	assign hiy      = posy_cur + tsize;
	assign lox      = (i_q == '0) ? {1'b0, job.dx} : posx_cur;
	assign loy      = (j_q == '0) ? {1'b0, job.dy} : posy_cur;
	assign endx_c   = (hix < job.endx) ? hix : job.endx;
	assign endy_c   = (hiy < job.endy) ? hiy : job.endy;
	assign pw       = endx_c - lox;
	assign ph       = endy_c - loy;

	assign col      = lox[15:0] >> cfg.ts;
	assign row      = loy[15:0] >> cfg.ts;
	assign oor      = (col >= 16'(side)) || (row >= 16'(side));
	assign idx_full = 13'(row[5:0]) * 13'(side) + 13'(col[5:0]);

	assign last_row = (j_q == PIDX_W'(job.ny - 1'b1));
	assign last_col = (i_q == PIDX_W'(job.nx - 1'b1));
	assign last     = job.empty || (last_row && last_col);

	always_comb begin
		gen = '0;
		if (job.empty) begin
			gen.pc.empty_res   = 1'b1;
			gen.pc.final_piece = 1'b1;
		end else begin
			gen.pc.piece_src_x  = job.sdx + lox[15:0];
			gen.pc.piece_src_y  = job.sdy + loy[15:0];
			gen.pc.piece_w      = pw[10:0];
			gen.pc.piece_h      = ph[10:0];
			gen.pc.tile_index   = oor ? 12'd0 : idx_full[11:0];
			gen.pc.local_x      = lox[9:0] & mask;
			gen.pc.local_y      = loy[9:0] & mask;
			gen.pc.out_of_range = oor;
			gen.pc.truncated    = last && job.trunc;
			gen.pc.final_piece  = last;
			gen.mark            = !oor;
			gen.idx             = idx_full[AW-1:0];
		end
	end

	assign job_pop = en && gen_v && last;

	// Clearing pass after reset, then run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= AW'(clr_addr_q + 1'b1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign clear_busy = (state_q == ST_CLEAR);

	// Tile store: clear sweep, mark on the stage-2 handoff, read for stage 1.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			tile_in_use_q[clr_addr_q] <= 1'b0;
		end else if (en && s2_v && s2.mark) begin
			tile_in_use_q[s2.idx] <= 1'b1;
		end
		if (en) begin
			rd_q <= tile_in_use_q[s1.idx];
		end
	end

	// Slot counters, column-major.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (en && gen_v) begin
			if (last) begin
				i_q <= '0;
				j_q <= '0;
			end else if (last_row) begin
				j_q <= '0;
				i_q <= PIDX_W'(i_q + 1'b1);
			end else begin
				j_q <= PIDX_W'(j_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && gen_v && !last) begin
			if (last_row) begin
				posx_q <= hix;
			end else begin
				posy_q <= hiy;
			end
		end
	end

	// Pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v          <= 1'b0;
			s2_v          <= 1'b0;
			piece_valid_q <= 1'b0;
		end else if (en) begin
			s1_v          <= gen_v;
			s2_v          <= s1_v;
			piece_valid_q <= s2_v;
		end
	end

	// Merge the stage-2 piece with its tile lookup.
	always_comb begin
		piece_d            = s2.pc;
		piece_d.newly_used = s2.mark && !(rd_q || s2_hit);
	end

	// Pipeline payload; the hit flag covers a mark written in the same cycle
	// as the read of the next piece.
	always_ff @(posedge clk) begin
		if (en) begin
			s1      <= gen;
			s2      <= s1;
			s2_hit  <= s2_v && s2.mark && (s2.idx == s1.idx);
			piece_q <= piece_d;
		end
	end

	assign piece_valid = piece_valid_q;
	assign piece       = piece_q;

	`BRTS_ASSERT_IMPL(a_back_clear_quiet, state_q == ST_CLEAR, !s1_v && !s2_v && !piece_valid_q, "piece in flight during clear")
	`BRTS_ASSERT_IMPL(a_back_newly_marked, piece_valid_q && piece_q.newly_used, !piece_q.out_of_range && !piece_q.empty_res, "newly_used on unmarked piece")
	`BRTS_ASSERT_IMPL(a_back_slot_bound, gen_v && !job.empty, (brts_pkg::PCNT_W'(i_q) < job.nx) && (brts_pkg::PCNT_W'(j_q) < job.ny), "slot counter past job count")

endmodule

`default_nettype wire

@@ design/blit_rect_tile_splitter_top.sv @@
// Channel  | handshake               | payload
// ---------+-------------------------+------------------------------------
// cfg      | cfg_we (no wait)        | cfg_idx, cfg_wdata (tile/row shift)
// req      | req_valid / req_ready   | req  (brts_pkg::req_t), one request
// piece    | piece_valid/piece_ready | piece (brts_pkg::piece_t), per tile
//
// The front end takes one request per cycle while the job queue has room and
// the tile store is not clearing. The back end emits one piece per cycle:
// nx*ny per request (1 to 64), or one without pieces, via s1, s2 and piece_q.
// After reset the tile store is cleared one entry a cycle, MAX_TILES_PER_SIDE
// squared entries capped at 64 per side (4096 by default); req_ready
// stays low until that pass ends. A stalled piece output freezes the back end.
//
// Top level of the blit tile splitter; depends on brts_pkg, brts_front,
// brts_jobq and brts_back.
`timescale 1ns / 1ps
`default_nettype none

module blit_rect_tile_splitter_top #(
	parameter int MAX_TILES_PER_SIDE  = brts_pkg::MAX_TILES_PER_SIDE_DEF,
	parameter int MAX_PIECES_PER_AXIS = brts_pkg::MAX_PIECES_PER_AXIS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [brts_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [brts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire brts_pkg::req_t                  req,
	output logic                                 piece_valid,
	input  wire logic                            piece_ready,
	output brts_pkg::piece_t                     piece
);

	logic [3:0]     tile_shift_q;
	logic [2:0]     row_shift_q;
	brts_pkg::cfg_t cfg;

	logic           push, q_full, q_valid, job_pop, clear_busy;
	brts_pkg::job_t job_in, job_out;

	// Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_shift_q <= 4'd8;
			row_shift_q  <= 3'd3;
		end else if (cfg_we) begin
			case (brts_pkg::cfg_reg_t'(cfg_idx))
				brts_pkg::REG_TILE_SHIFT: begin
					tile_shift_q <= cfg_wdata;
				end
				brts_pkg::REG_ROW_SHIFT: begin
					row_shift_q <= cfg_wdata[2:0];
				end
				default: begin
					tile_shift_q <= tile_shift_q;
				end
			endcase
		end
	end

	// Clamp oversized shifts to the largest tile and grid.
	assign cfg.ts = (tile_shift_q > 4'(brts_pkg::TS_MAX)) ? 4'(brts_pkg::TS_MAX) : tile_shift_q;
	assign cfg.rs = (row_shift_q > 3'(brts_pkg::RS_MAX)) ? 3'(brts_pkg::RS_MAX) : row_shift_q;

	// Classify the request into slot counts and axis bounds.
	brts_front #(
		.MAX_PIECES_PER_AXIS(MAX_PIECES_PER_AXIS)
	) u_front (
		.tile_shift (cfg.ts),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.q_full     (q_full),
		.clear_busy (clear_busy),
		.push       (push),
		.job        (job_in)
	);

	// Decouple request intake from piece emission.
	brts_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (q_full),
		.pop    (job_pop),
		.valid  (q_valid),
		.rdata  (job_out)
	);

	// Walk the tiles, track tile use, drive the output register.
	brts_back #(
		.MAX_TILES_PER_SIDE  (MAX_TILES_PER_SIDE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.job_valid   (q_valid),
		.job         (job_out),
		.job_pop     (job_pop),
		.clear_busy  (clear_busy),
		.piece_valid (piece_valid),
		.piece_ready (piece_ready),
		.piece       (piece)
	);

endmodule

`default_nettype wire
